### design/fvm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvm_pkg
// Shared widths, Q.30 constants, the arctangent table and the word types
// of the four-vector converter and invariant-mass pipeline.
// ---------------------------------------------------------------------------
package fvm_pkg;

  // Pipeline geometry
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ATAN_ENTRIES      = 40;
  localparam int EXP_TERMS         = 12;
  localparam int EXP_CELL_LAT      = 3;
  localparam int EXP_LAT           = EXP_TERMS * EXP_CELL_LAT;
  localparam int ROOT_BITS         = 40;
  localparam int K_THRESH          = 12;

  // Field and datapath widths
  localparam int PT_W   = 24;
  localparam int ANG_W  = 16;
  localparam int PIN_W  = 32;
  localparam int V_W    = 40;
  localparam int X_W    = 34;
  localparam int Z_W    = 36;
  localparam int R_W    = 31;
  localparam int E_W    = 32;
  localparam int K_W    = 5;
  localparam int D_W    = 80;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 200;

  // Q.30 constants
  localparam longint Q30_ONE      = 64'd1073741824;
  localparam longint Q30_PI       = 64'd3373259426;
  localparam longint Q30_HALF_PI  = 64'd1686629713;
  localparam longint Q30_LN2      = 64'd744261118;
  localparam longint Q30_HALF_LN2 = 64'd372130559;
  localparam longint Q30_KINV     = 64'd652032874;

  localparam logic [V_W-1:0] U40_MAX = '1;

  // Truncated atan(2^-i) in Q.30
  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0,
    30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
  };

  // Per-item fields that ride beside the CORDIC and exponential chains
  typedef struct packed {
    logic                    neg;
    logic signed [K_W-1:0]   k;
    logic                    kind;
    logic [PT_W-1:0]         pt;
    logic signed [PIN_W-1:0] px_in;
    logic signed [PIN_W-1:0] py_in;
    logic signed [PIN_W-1:0] pz_in;
    logic signed [V_W-1:0]   energy;
  } side_t;

  // Final cartesian four-vector
  typedef struct packed {
    logic signed [V_W-1:0] px;
    logic signed [V_W-1:0] py;
    logic signed [V_W-1:0] pz;
    logic signed [V_W-1:0] e;
  } vec_t;

  // Range-reduction threshold: half ln2 plus j whole ln2 steps
  function automatic logic signed [Z_W-1:0] eta_thresh(input int j);
    return Z_W'(Q30_HALF_LN2 + longint'(j) * Q30_LN2);
  endfunction

endpackage

### design/fvm_delay.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvm_delay
// Enabled register line that keeps side fields in step with a chain.
// ---------------------------------------------------------------------------
module fvm_delay import fvm_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  generate
    if (DEPTH == 0) begin : g_none
      assign d_o = d_i;
    end else begin : g_line
      logic [W-1:0] tap_r [DEPTH];

      // Shift the line on every advance
      always_ff @(posedge clk) begin
        if (ce) begin
          tap_r[0] <= d_i;
          for (int i = 1; i < DEPTH; i++) begin
            tap_r[i] <= tap_r[i-1];
          end
        end
      end

      assign d_o = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

### design/fvm_cordic_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvm_cordic_cell
// One registered rotation of the circular CORDIC toward angle zero.
// ---------------------------------------------------------------------------
module fvm_cordic_cell import fvm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [X_W-1:0] x_i,
  input  logic signed [X_W-1:0] y_i,
  input  logic signed [Z_W-1:0] z_i,
  output logic signed [X_W-1:0] x_o,
  output logic signed [X_W-1:0] y_o,
  output logic signed [Z_W-1:0] z_o
);

  localparam logic signed [Z_W-1:0] ANG = $signed(Z_W'(ATAN_Q30[IDX]));

  logic signed [X_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic signed [X_W-1:0] dx, dy;

  // Rotate by the fixed micro-angle in the direction of the residual
  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[Z_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

### design/fvm_exp_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvm_exp_cell
// One Horner term e = 1 + floor(r*e / 2^30) / N of the exponential series,
// three registers deep: product, reciprocal quotient, correction.
// ---------------------------------------------------------------------------
module fvm_exp_cell import fvm_pkg::*; #(
  parameter int N = 1
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [R_W-1:0] r_i,
  input  logic signed [E_W-1:0] e_i,
  output logic signed [R_W-1:0] r_o,
  output logic signed [E_W-1:0] e_o
);

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
  localparam int PROD_W = R_W + E_W;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [R_W-1:0]    ra_r, rb_r, rc_r;
  logic                     sg_r;
  logic [30:0]              a_r, q0_r;
  logic signed [E_W-1:0]    e_r;

  logic signed [32:0] v;
  logic [30:0]        a_nxt;
  logic [63:0]        ar;
  logic [34:0]        qn, rem;
  logic [30:0]        q;
  logic signed [E_W-1:0] e_nxt;

  // Floor-shift, then truncating divide by N through its reciprocal
  always_comb begin
    v     = prod_r[PROD_W-1:30];
    a_nxt = 31'(v[32] ? -v : v);
    ar    = {33'd0, a_nxt} * {31'd0, RECIP};
    qn    = 35'(q0_r) * 35'(N);
    rem   = 35'(a_r) - qn;
    q     = q0_r + 31'(rem >= 35'(N));
    e_nxt = E_W'(Q30_ONE) + (sg_r ? -$signed(E_W'(q)) : $signed(E_W'(q)));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= r_i * e_i;
      ra_r   <= r_i;
      sg_r   <= v[32];
      a_r    <= a_nxt;
      q0_r   <= 31'(ar >> 32);
      rb_r   <= ra_r;
      e_r    <= e_nxt;
      rc_r   <= rb_r;
    end
  end

  assign r_o = rc_r;
  assign e_o = e_r;

endmodule

### design/fvm_root_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvm_root_cell
// One registered digit of a restoring square root: try setting bit BIT
// of the root and keep it when the remainder allows.
// ---------------------------------------------------------------------------
module fvm_root_cell import fvm_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [D_W-1:0]       rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  output logic [D_W-1:0]       rem_o,
  output logic [ROOT_BITS-1:0] root_o
);

  logic [D_W:0]           t;
  logic [D_W-1:0]         rem_r;
  logic [ROOT_BITS-1:0]   root_r;
  logic                   take;

  // Increase of root^2 when this bit is set: 2*root*2^BIT + 2^(2*BIT)
  always_comb begin
    t    = ((D_W+1)'(root_i) << (BIT + 1)) + ((D_W+1)'(1) << (2 * BIT));
    take = t <= {1'b0, rem_i};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r  <= take ? D_W'({1'b0, rem_i} - t) : rem_i;
      root_r <= take ? (root_i | (ROOT_BITS'(1) << BIT)) : root_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

### design/four_vector_convert_and_mass.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// four_vector_convert_and_mass
// Converts particle four-vectors to cartesian form and computes the
// invariant mass sqrt(|E^2 - p^2|), one word per clock when not stalled.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one four-vector per word; in_tuser[0] is the kind (0 = pt, eta,
//           phi, energy; 1 = px, py, pz, energy).
//   out_* : one result word per input word, in order; out_tuser[0] flags a
//           clipped mass.
// Path: the front register, the longer of the 12-term exponential chain
//   and the CORDIC chain, the P1 to P6 registers, the 40-digit square-root
//   chain and the P7 output register.
// Throughput: one word per cycle while not stalled; stages fully pipelined.
// Stall: a result held on out_* with out_tready low freezes the whole
//   pipeline, and in_tready follows out_tready in that cycle.
// Reset: clears the valid line only; no clearing pass, ready right away.
// Momenta never exceed 40 bits, so only the mass can clip.
// ---------------------------------------------------------------------------
module four_vector_convert_and_mass import fvm_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pt[23:0], eta[39:24], phi[55:40], px_in[87:56], py_in[119:88],
  // pz_in[151:120], energy[191:152]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // px_out[39:0], py_out[79:40], pz_out[119:80], e_out[159:120],
  // mass[199:160]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // saturated[0]
  output logic [0:0]            out_tuser
);

  localparam int CHAIN_LAT = (CORDIC_STAGES > EXP_LAT) ? CORDIC_STAGES : EXP_LAT;
  localparam int LAT       = 1 + CHAIN_LAT + 6 + ROOT_BITS + 1;
  localparam int SIDE_W    = $bits(side_t);
  localparam int VEC_W     = $bits(vec_t);

  logic           adv;
  logic [LAT-1:0] v_r;

  // Advance everything unless a result is waiting
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------- front: angle fold and eta range reduction ----------
  logic signed [ANG_W-1:0] eta, phi;
  logic signed [Z_W-1:0]   z0, r0, z_nxt, kl, r_full;
  logic [3:0]              pos_cnt, neg_cnt;
  logic signed [K_W-1:0]   k_nxt;
  side_t                   side_nxt, f_side_r;
  logic signed [Z_W-1:0]   f_z_r;
  logic signed [R_W-1:0]   f_r_r;

  always_comb begin
    eta = in_tdata[39:24];
    phi = in_tdata[55:40];
    z0  = {{3{phi[ANG_W-1]}}, phi, 17'd0};
    r0  = {{2{eta[ANG_W-1]}}, eta, 18'd0};

    side_nxt.neg = 1'b0;
    z_nxt        = z0;
    if (z0 > $signed(Z_W'(Q30_HALF_PI))) begin
      z_nxt        = z0 - $signed(Z_W'(Q30_PI));
      side_nxt.neg = 1'b1;
    end else if (z0 < -$signed(Z_W'(Q30_HALF_PI))) begin
      z_nxt        = z0 + $signed(Z_W'(Q30_PI));
      side_nxt.neg = 1'b1;
    end

    // Count ln2 steps needed to bring r within half ln2
    pos_cnt = '0;
    neg_cnt = '0;
    for (int j = 0; j < K_THRESH; j++) begin
      pos_cnt = pos_cnt + 4'(r0 > eta_thresh(j));
      neg_cnt = neg_cnt + 4'(r0 < -eta_thresh(j));
    end
    k_nxt  = $signed(K_W'(pos_cnt)) - $signed(K_W'(neg_cnt));
    kl     = Z_W'(k_nxt);
    r_full = r0 - kl * $signed(Z_W'(Q30_LN2));

    side_nxt.k      = k_nxt;
    side_nxt.kind   = in_tuser[0];
    side_nxt.pt     = in_tdata[23:0];
    side_nxt.px_in  = in_tdata[87:56];
    side_nxt.py_in  = in_tdata[119:88];
    side_nxt.pz_in  = in_tdata[151:120];
    side_nxt.energy = in_tdata[191:152];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side_r <= side_nxt;
      f_z_r    <= z_nxt;
      f_r_r    <= R_W'(r_full);
    end
  end

  // ---------------- CORDIC chain ----------------------------------------
  logic signed [X_W-1:0] cx [CORDIC_STAGES+1];
  logic signed [X_W-1:0] cy [CORDIC_STAGES+1];
  logic signed [Z_W-1:0] cz [CORDIC_STAGES+1];
  logic [2*X_W-1:0]      cxy_d;
  logic signed [X_W-1:0] cos_d, sin_d;

  assign cx[0] = X_W'(Q30_KINV);
  assign cy[0] = '0;
  assign cz[0] = f_z_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    fvm_cordic_cell #(.IDX(i)) u_cell (
      .clk(clk), .ce(adv),
      .x_i(cx[i]), .y_i(cy[i]), .z_i(cz[i]),
      .x_o(cx[i+1]), .y_o(cy[i+1]), .z_o(cz[i+1])
    );
  end

  fvm_delay #(.W(2*X_W), .DEPTH(CHAIN_LAT - CORDIC_STAGES)) u_cordic_pad (
    .clk(clk), .ce(adv),
    .d_i({cx[CORDIC_STAGES], cy[CORDIC_STAGES]}), .d_o(cxy_d)
  );
  assign cos_d = cxy_d[2*X_W-1:X_W];
  assign sin_d = cxy_d[X_W-1:0];

  // ---------------- exponential chains for e^r and e^-r -----------------
  logic signed [R_W-1:0] pr [EXP_TERMS+1];
  logic signed [E_W-1:0] pe [EXP_TERMS+1];
  logic signed [R_W-1:0] mr [EXP_TERMS+1];
  logic signed [E_W-1:0] me [EXP_TERMS+1];
  logic [2*E_W-1:0]      exp_d;
  logic signed [E_W-1:0] ep_d, em_d;

  assign pr[0] = f_r_r;
  assign pe[0] = E_W'(Q30_ONE);
  assign mr[0] = -f_r_r;
  assign me[0] = E_W'(Q30_ONE);

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
    fvm_exp_cell #(.N(EXP_TERMS - i)) u_pos (
      .clk(clk), .ce(adv),
      .r_i(pr[i]), .e_i(pe[i]), .r_o(pr[i+1]), .e_o(pe[i+1])
    );
    fvm_exp_cell #(.N(EXP_TERMS - i)) u_neg (
      .clk(clk), .ce(adv),
      .r_i(mr[i]), .e_i(me[i]), .r_o(mr[i+1]), .e_o(me[i+1])
    );
  end

  fvm_delay #(.W(2*E_W), .DEPTH(CHAIN_LAT - EXP_LAT)) u_exp_pad (
    .clk(clk), .ce(adv),
    .d_i({pe[EXP_TERMS], me[EXP_TERMS]}), .d_o(exp_d)
  );
  assign ep_d = exp_d[2*E_W-1:E_W];
  assign em_d = exp_d[E_W-1:0];

  // Side fields in step with the chains
  logic [SIDE_W-1:0] side_bits_d;
  side_t             c_side;

  fvm_delay #(.W(SIDE_W), .DEPTH(CHAIN_LAT)) u_side_pad (
    .clk(clk), .ce(adv), .d_i(f_side_r), .d_o(side_bits_d)
  );
  assign c_side = side_t'(side_bits_d);

  // ---------------- P1: scale by pt -------------------------------------
  logic signed [X_W:0]  xf, yf;
  logic signed [59:0]   pxp_r, pyp_r;
  logic [55:0]          pzp_r, pzm_r;
  side_t                s1_r;

  always_comb begin
    xf = c_side.neg ? -(X_W+1)'(cos_d) : (X_W+1)'(cos_d);
    yf = c_side.neg ? -(X_W+1)'(sin_d) : (X_W+1)'(sin_d);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxp_r <= $signed({1'b0, c_side.pt}) * xf;
      pyp_r <= $signed({1'b0, c_side.pt}) * yf;
      pzp_r <= 56'(c_side.pt) * 56'(ep_d[E_W-1:0]);
      pzm_r <= 56'(c_side.pt) * 56'(em_d[E_W-1:0]);
      s1_r  <= c_side;
    end
  end

  // ---------------- P2: round, rescale by 2^k, pick the form ------------
  logic signed [60:0] pxs, pys;
  logic [5:0]         sh_p, sh_m;
  logic [56:0]        rnd_p, rnd_m;
  vec_t               vec_nxt, m2_r;

  always_comb begin
    pxs   = 61'(pxp_r) + 61'sd536870912;
    pys   = 61'(pyp_r) + 61'sd536870912;
    sh_p  = 6'(6'd31 - 6'(s1_r.k));
    sh_m  = 6'(6'd31 + 6'(s1_r.k));
    rnd_p = ({1'b0, pzp_r} + (57'd1 << (sh_p - 6'd1))) >> sh_p;
    rnd_m = ({1'b0, pzm_r} + (57'd1 << (sh_m - 6'd1))) >> sh_m;
    if (s1_r.kind) begin
      vec_nxt.px = V_W'(s1_r.px_in);
      vec_nxt.py = V_W'(s1_r.py_in);
      vec_nxt.pz = V_W'(s1_r.pz_in);
    end else begin
      vec_nxt.px = V_W'(pxs >>> 30);
      vec_nxt.py = V_W'(pys >>> 30);
      vec_nxt.pz = $signed(V_W'(rnd_p)) - $signed(V_W'(rnd_m));
    end
    vec_nxt.e = s1_r.energy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r <= vec_nxt;
    end
  end

  // ---------------- P3: 20-bit partial products of each square ---------
  logic [V_W-1:0] mag [4];
  logic [V_W-1:0] hh_r [4];
  logic [V_W-1:0] hl_r [4];
  logic [V_W-1:0] ll_r [4];
  vec_t           m3_r;

  always_comb begin
    mag[0] = m2_r.px[V_W-1] ? -m2_r.px : m2_r.px;
    mag[1] = m2_r.py[V_W-1] ? -m2_r.py : m2_r.py;
    mag[2] = m2_r.pz[V_W-1] ? -m2_r.pz : m2_r.pz;
    mag[3] = m2_r.e[V_W-1]  ? -m2_r.e  : m2_r.e;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        hh_r[i] <= V_W'(mag[i][39:20]) * V_W'(mag[i][39:20]);
        hl_r[i] <= V_W'(mag[i][39:20]) * V_W'(mag[i][19:0]);
        ll_r[i] <= V_W'(mag[i][19:0])  * V_W'(mag[i][19:0]);
      end
      m3_r <= m2_r;
    end
  end

  // ---------------- P4: assemble squares --------------------------------
  logic [D_W-1:0] sq_r [4];
  vec_t           m4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= (D_W'(hh_r[i]) << 40) + (D_W'(hl_r[i]) << 21) + D_W'(ll_r[i]);
      end
      m4_r <= m3_r;
    end
  end

  // ---------------- P5: momentum square sum -----------------------------
  logic [D_W-1:0] p2_r, e2_r;
  vec_t           m5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= sq_r[0] + sq_r[1] + sq_r[2];
      e2_r <= sq_r[3];
      m5_r <= m4_r;
    end
  end

  // ---------------- P6: absolute Minkowski norm -------------------------
  logic [D_W-1:0] d_r;
  vec_t           m6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r  <= (p2_r <= e2_r) ? (e2_r - p2_r) : (p2_r - e2_r);
      m6_r <= m5_r;
    end
  end

  // ---------------- square-root chain -----------------------------------
  logic [D_W-1:0]       rt_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] rt_root [ROOT_BITS+1];
  logic [VEC_W-1:0]     vec_bits_d;
  vec_t                 mr_vec;

  assign rt_rem[0]  = d_r;
  assign rt_root[0] = '0;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
    fvm_root_cell #(.BIT(ROOT_BITS - 1 - i)) u_cell (
      .clk(clk), .ce(adv),
      .rem_i(rt_rem[i]), .root_i(rt_root[i]),
      .rem_o(rt_rem[i+1]), .root_o(rt_root[i+1])
    );
  end

  fvm_delay #(.W(VEC_W), .DEPTH(ROOT_BITS)) u_vec_pad (
    .clk(clk), .ce(adv), .d_i(m6_r), .d_o(vec_bits_d)
  );
  assign mr_vec = vec_t'(vec_bits_d);

  // ---------------- P7: round the root, clip, output register -----------
  logic [ROOT_BITS:0] mass_rnd;
  logic [V_W-1:0]     mass_nxt;
  logic               sat_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_sat_r;

  always_comb begin
    mass_rnd = (ROOT_BITS+1)'(rt_root[ROOT_BITS])
             + (ROOT_BITS+1)'(rt_rem[ROOT_BITS] > D_W'(rt_root[ROOT_BITS]));
    sat_nxt  = mass_rnd[ROOT_BITS];
    mass_nxt = sat_nxt ? U40_MAX : mass_rnd[V_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {mass_nxt, mr_vec.e, mr_vec.pz, mr_vec.py, mr_vec.px};
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_tvalid   = v_r[LAT-1];
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_sat_r;

  // ---------------- assertions ------------------------------------------
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (f_side_r.k >= -5'sd12) && (f_side_r.k <= 5'sd12))
    else $error("eta reduction step count out of range");

  a_exp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[CHAIN_LAT] |-> (ep_d > 0) && (em_d > 0))
    else $error("exponential chain produced a non-positive value");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAT-2] |->
      ((D_W+1)'(rt_rem[ROOT_BITS]) <= ((D_W+1)'(rt_root[ROOT_BITS]) << 1)))
    else $error("square-root remainder exceeds twice the root");

  a_sat_mass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[199:160] == U40_MAX))
    else $error("saturated flag without clipped mass");

endmodule
